@@ src/hpfc_pkg.sv @@
// hpfc_pkg: shared types and constants for the half precision converter
// no dependencies; imported by hpfc_narrow, hpfc_widen and the top level
package hpfc_pkg;

  typedef enum logic [1:0] {
    REQ_S2H = 2'd0,
    REQ_D2H = 2'd1,
    REQ_H2S = 2'd2,
    REQ_H2D = 2'd3
  } req_type_t;

  localparam logic [15:0] H_SIGN = 16'h8000;
  localparam logic [15:0] H_EXP  = 16'h7c00;
  localparam logic [9:0]  H_MANT = 10'h3ff;
  localparam int          H_BIAS = 15;

  // rebias offsets between source exponent and binary16 exponent
  localparam logic [12:0] S_REBIAS = 13'd112;
  localparam logic [12:0] D_REBIAS = 13'd1008;

endpackage

@@ src/half_precision_float_converter.sv @@
// half_precision_float_converter: top level, input register, conversion, result register
// depends on hpfc_pkg, hpfc_narrow, hpfc_widen
//
// Usage:
//   Input channel: in_valid, in_stall, in_req_type, in_operand_bits. A beat is
//   taken on a rising edge with in_valid high and in_stall low.
//   in_req_type selects single to half, double to half, half to single or
//   half to double; unused high operand bits are ignored.
//   Result channel: out_valid, out_stall, out_result_bits, zero-extended above
//   the target format width.
//   The accepted beat is held in the input register, converted, and then
//   registered in the result register, which drives out_valid. One beat per
//   cycle is sustained while the receiver does not stall; the conversion is a
//   single combinational pass between the input register and the result register.
//   When the receiver stalls, the result register holds, the input register
//   still fills once, and then in_stall rises until the result moves on.
//   Synchronous reset (rst_n low) empties both registers; there is no other
//   state.
module half_precision_float_converter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  hpfc_pkg::req_type_t  in_req_type,
  input  logic [63:0]          in_operand_bits,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [63:0]          out_result_bits
);
  import hpfc_pkg::*;

  logic        s1_valid_r;
  req_type_t   s1_type_r;
  logic [63:0] s1_op_r;
  logic        s2_valid_r;
  logic [63:0] s2_res_r;
  logic        s1_adv;
  logic [15:0] nar_res;
  logic [63:0] wid_res;
  logic [63:0] conv;

  hpfc_narrow u_narrow (
    .is_double (s1_type_r == REQ_D2H),
    .operand   (s1_op_r),
    .result    (nar_res)
  );

  hpfc_widen u_widen (
    .is_double (s1_type_r == REQ_H2D),
    .operand   (s1_op_r[15:0]),
    .result    (wid_res)
  );

  // select converter output
  always_comb begin
    unique case (s1_type_r)
      REQ_S2H, REQ_D2H: conv = {48'd0, nar_res};
      default:          conv = wid_res;
    endcase
  end

  // handshake
  assign s1_adv    = !s2_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !s1_adv;
  assign out_valid = s2_valid_r;
  assign out_result_bits = s2_res_r;

  // input beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_type_r <= in_req_type;
      s1_op_r   <= in_operand_bits;
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      s2_res_r <= conv;
    end
  end

  a_stall_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s2_valid_r && out_stall))
    else $error("input stalled without a held beat");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> s1_valid_r)
    else $error("accepted beat lost");

  a_beat_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_adv) |=> s2_valid_r)
    else $error("converted beat not registered");

endmodule

@@ src/hpfc_narrow.sv @@
// hpfc_narrow: binary32 or binary64 to binary16, round to nearest even
// depends on hpfc_pkg
module hpfc_narrow (
  input  logic        is_double,
  input  logic [63:0] operand,
  output logic [15:0] result
);
  import hpfc_pkg::*;

  logic               sign;
  logic [10:0]        efield;
  logic               emax;
  logic [51:0]        mant;
  logic               sticky;
  logic signed [12:0] hexp;
  logic [52:0]        r_sub;
  logic [52:0]        r_norm;
  logic [3:0]         shamt;
  logic [9:0]         hm;
  logic [15:0]        sum;

  // unpack source fields, single mantissa padded to 52 bits
  always_comb begin
    if (is_double) begin
      sign   = operand[63];
      efield = operand[62:52];
      emax   = (operand[62:52] == 11'h7ff);
      mant   = operand[51:0];
      sticky = |operand[10:0];
      hexp   = $signed({2'b00, operand[62:52]}) - $signed(D_REBIAS);
    end else begin
      sign   = operand[31];
      efield = {3'b000, operand[30:23]};
      emax   = (operand[30:23] == 8'hff);
      mant   = {operand[22:0], 29'd0};
      sticky = |operand[10:0];
      hexp   = $signed({2'b00, efield}) - $signed(S_REBIAS);
    end
  end

  // classify and round
  always_comb begin
    shamt  = 4'(13'sd1 - hexp);
    r_sub  = {1'b1, mant} >> shamt;
    if ((r_sub[42:0] != 43'h200_0000_0000) || sticky) begin
      r_sub = r_sub + 53'h200_0000_0000;
    end
    r_norm = {1'b0, mant};
    if (r_norm[42:0] != 43'h200_0000_0000) begin
      r_norm = r_norm + 53'h200_0000_0000;
    end
    hm  = mant[51:42];
    sum = 16'd0;
    if (hexp >= 13'sd31) begin
      if (emax && (mant != 52'd0)) begin
        sum = {sign, 15'd0} | H_EXP | {6'd0, ((hm == 10'd0) ? 10'd1 : hm)};
      end else begin
        sum = {sign, 15'd0} | H_EXP;
      end
    end else if (hexp < -13'sd10) begin
      sum = {sign, 15'd0};
    end else if (hexp <= 13'sd0) begin
      sum = {sign, 15'd0} + {5'd0, r_sub[52:42]};
    end else begin
      sum = {sign, 15'd0} + {1'b0, hexp[4:0], 10'd0} + {5'd0, r_norm[52:42]};
    end
    result = sum;
  end

endmodule

@@ src/hpfc_widen.sv @@
// hpfc_widen: binary16 to binary32 or binary64, exact
// depends on hpfc_pkg
module hpfc_widen (
  input  logic        is_double,
  input  logic [15:0] operand,
  output logic [63:0] result
);
  import hpfc_pkg::*;

  logic        sign;
  logic [4:0]  he;
  logic [9:0]  hm;
  logic [3:0]  p;
  logic [10:0] shifted;
  logic [9:0]  mout;
  logic [10:0] eout;

  // leading one position of a subnormal mantissa
  always_comb begin
    p = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (hm[i]) begin
        p = 4'(i);
      end
    end
  end

  always_comb begin
    sign    = operand[15];
    he      = operand[14:10];
    hm      = operand[9:0];
    shifted = {1'b0, hm} << (4'd10 - p);
    mout    = hm;
    eout    = 11'd0;
    if (he == 5'h1f) begin
      eout = 11'h7ff;
    end else if (he == 5'd0) begin
      if (hm != 10'd0) begin
        eout = is_double ? (11'd999 + {7'd0, p}) : (11'd103 + {7'd0, p});
        mout = shifted[9:0];
      end
    end else begin
      eout = {6'd0, he} + (is_double ? 11'd1008 : 11'd112);
    end
    if (is_double) begin
      result = {sign, eout, mout, 42'd0};
    end else begin
      result = {32'd0, sign, eout[7:0], mout, 13'd0};
    end
  end

endmodule

@@ tb/sv/hpfc_checker.sv @@
// hpfc_checker: watches both channels of the half precision converter,
// predicts each result and compares; depends on hpfc_pkg
`timescale 1ns / 1ps
module hpfc_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  hpfc_pkg::req_type_t in_req_type,
  input  logic [63:0]         in_operand_bits,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [63:0]         out_result_bits,
  output int                  fail_count,
  output int                  pending
);
  import hpfc_pkg::*;

  logic [63:0] expected_q[$];

  // narrow binary32 (mb 23, eb 8) or binary64 (mb 52, eb 11) to binary16
  function automatic logic [63:0] to_half(logic [63:0] f, int total, int mb, int eb);
    logic [63:0] sgn, emax, ef, mant, rb, lowm, r;
    int bias, hexp;
    sgn = (f >> (total - 16)) & 64'h8000;
    emax = (64'd1 << eb) - 1;
    ef = (f >> mb) & emax;
    mant = f & ((64'd1 << mb) - 1);
    bias = (1 << (eb - 1)) - 1;
    hexp = int'(ef) - bias + H_BIAS;
    rb = 64'd1 << (mb - 11);
    lowm = (rb << 2) - 1;
    if (hexp >= 31) begin
      if (ef == emax && mant != 0) begin
        r = mant >> (mb - 10);
        if (r == 0) r = 1;
        return sgn | 64'h7c00 | r;
      end
      return sgn | 64'h7c00;
    end
    if (hexp <= 0) begin
      if (hexp < -10) return sgn;
      r = ((64'd1 << mb) | mant) >> (1 - hexp);
      if ((r & lowm) != rb || (mant & 64'h7ff) != 0) r += rb;
      return sgn + (r >> (mb - 10));
    end
    r = mant;
    if ((r & lowm) != rb) r += rb;
    return sgn + (64'(hexp) << 10) + (r >> (mb - 10));
  endfunction

  // widen binary16 to binary32 or binary64, exact
  function automatic logic [63:0] from_half(logic [15:0] h, int total, int mb, int eb);
    logic [63:0] sgn, bias, expm, hm, e, m;
    int p;
    sgn = 64'(h & 16'h8000) << (total - 16);
    hm = 64'(h[9:0]);
    bias = (64'd1 << (eb - 1)) - 1;
    expm = ((64'd1 << eb) - 1) << mb;
    if (h[14:10] == 5'h1f) return sgn | expm | (hm << (mb - 10));
    if (h[14:10] == 0) begin
      if (hm == 0) return sgn;
      p = 9;
      while (p > 0 && hm[p] == 1'b0) p--;
      e = bias + 64'(p) - 24;
      m = (hm << (10 - p)) & 64'h3ff;
      return sgn | (e << mb) | (m << (mb - 10));
    end
    return sgn | ((64'(h & 16'h7fff) + ((bias - 15) << 10)) << (mb - 10));
  endfunction

  function automatic logic [63:0] convert(req_type_t rt, logic [63:0] op);
    case (rt)
      REQ_S2H: return to_half({32'd0, op[31:0]}, 32, 23, 8);
      REQ_D2H: return to_half(op, 64, 52, 11);
      REQ_H2S: return from_half(op[15:0], 32, 23, 8);
      default: return from_half(op[15:0], 64, 52, 11);
    endcase
  endfunction

  assign pending = expected_q.size();

  // predict on input beats, compare on result beats
  always @(posedge clk) begin
    logic [63:0] want;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_q.push_back(convert(in_req_type, in_operand_bits));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat %h", out_result_bits);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want !== out_result_bits) begin
            if (fail_count < 10)
              $display("mismatch: expected %h actual %h", want, out_result_bits);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ tb/sv/tb_half_precision_float_converter.sv @@
// tb_half_precision_float_converter: stimulus and verdict for the converter
// depends on hpfc_pkg, half_precision_float_converter and hpfc_checker
`timescale 1ns / 1ps
module tb_half_precision_float_converter;
  import hpfc_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  req_type_t in_req_type = REQ_S2H;
  logic [63:0] in_operand_bits = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [63:0] out_result_bits;
  int fail_count, pending;
  int send_idle = 30, recv_idle = 60;
  int hold_cycles = 0;
  int cycles = 0;

  always #4 clk = ~clk;

  half_precision_float_converter uut (.*);
  hpfc_checker chk (.*);

  // global cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("tb_half_precision_float_converter failed");
      $finish;
    end
  end

  // receiver stall, with a long hold-off when requested
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // random operand biased toward interesting exponents
  function automatic logic [63:0] pick_operand(req_type_t rt);
    logic [63:0] v;
    v = rand64();
    case ($urandom_range(3))
      0: ;
      1: if (rt == REQ_S2H) v[30:23] = 8'd98 + 8'($urandom_range(35));
         else if (rt == REQ_D2H) v[62:52] = 11'd994 + 11'($urandom_range(35));
         else v[14:10] = $urandom_range(1) ? 5'd0 : 5'h1f;
      2: if (rt == REQ_S2H) v[30:23] = $urandom_range(1) ? 8'hff : 8'd142 + 8'($urandom_range(1));
         else if (rt == REQ_D2H) v[62:52] = $urandom_range(1) ? 11'h7ff : 11'd1038;
         else v[14:10] = 5'($urandom_range(31));
      default: if (rt == REQ_S2H) v[12:0] = $urandom_range(1) ? 13'h1000 : 13'h0fff;
               else if (rt == REQ_D2H) v[41:0] = $urandom_range(1) ? 42'h200_0000_0000 : 42'h0;
               else v[9:0] = 10'($urandom_range(3));
    endcase
    return v;
  endfunction

  // one input beat, waiting out idles and stalls
  task automatic send(req_type_t rt, logic [63:0] op);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_req_type <= rt;
    in_operand_bits <= op;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // let the last accepted beat reach the checker, then wait for all results
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [63:0] dir_ops[] = '{
      64'h0, 64'hffff_ffff_ffff_ffff, 64'h7f80_0000, 64'h7f80_0001, 64'h7fc0_0000,
      64'h477f_f000, 64'h477f_e000, 64'h3300_0000, 64'h3300_0001, 64'h3880_0000,
      64'h387f_f000, 64'h8000_0000_8000_0000, 64'h7ff0_0000_0000_0001,
      64'hfff8_0000_0000_0000, 64'h40ef_fe00_0000_0000, 64'h3e60_0000_0000_0000,
      64'h3f10_0000_0000_0001};
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: narrowing edge cases on both source widths, then widening
    foreach (dir_ops[i]) send(dir_ops[i][63:52] != 0 && dir_ops[i][31:0] == 0
                              || dir_ops[i] == 64'h3f10_0000_0000_0001
                              || dir_ops[i] == 64'h7ff0_0000_0000_0001 ? REQ_D2H : REQ_S2H,
                              dir_ops[i]);
    send(REQ_H2S, 64'h0000_0000_0000_0001);
    send(REQ_H2D, 64'hffff_ffff_ffff_83ff);
    send(REQ_H2S, 64'h7c00);
    send(REQ_H2D, 64'hfe01);
    send(REQ_H2S, 64'h0200);
    send(REQ_H2D, 64'h7bff);
    drain();
    // random phases with different idling
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 30 : (ph == 1) ? 60 : 0;
      recv_idle = (ph == 0) ? 60 : (ph == 1) ? 30 : 0;
      if (ph == 2) hold_cycles <= 40;
      for (int n = 0; n < 150; n++) begin
        req_type_t rt;
        rt = req_type_t'($urandom_range(3));
        send(rt, pick_operand(rt));
      end
      drain();
    end
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb_half_precision_float_converter passed");
    else
      $display("tb_half_precision_float_converter failed");
    $finish;
  end
endmodule
